// ===== hw/rtl/cws_pkg.sv =====
// ----------------------------------------------------------------------------
// cws_pkg: shared types and constants of the congestion window sender
// Field widths, function and result codes, register indexes and the
// command and status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package cws_pkg;

  localparam int MAX_WINDOW = 32;
  localparam int SEQ_BITS   = 16;

  localparam int WIN_W   = $clog2(MAX_WINDOW + 1);
  localparam int FUNC_W  = 2;
  localparam int KIND_W  = 3;
  localparam int TOTAL_W = 16;
  localparam int THR_W   = 6;
  localparam int TICK_W  = 20;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 20;

  localparam logic [WIN_W-1:0]  MAX_WINDOW_W  = WIN_W'(MAX_WINDOW);
  localparam logic [THR_W-1:0]  THR_RESET     = THR_W'(16);
  localparam logic [TICK_W-1:0] TIMEOUT_RESET = TICK_W'(1500);

  localparam logic [FUNC_W-1:0] FUNC_START = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_ACK   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_TICK  = 2'd2;

  localparam logic [KIND_W-1:0] KIND_NONE    = 3'd0;
  localparam logic [KIND_W-1:0] KIND_SEND    = 3'd1;
  localparam logic [KIND_W-1:0] KIND_RESEND  = 3'd2;
  localparam logic [KIND_W-1:0] KIND_TIMEOUT = 3'd3;
  localparam logic [KIND_W-1:0] KIND_FIN     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_ACK     = 3'd5;

  localparam logic [CFG_IDX_W-1:0] CFG_SEGMENT_TOTAL     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_THRESHOLD = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_TICKS     = 2'd2;

  typedef struct packed {
    logic load;
    logic exec;
    logic burst_init;
    logic burst_step;
  } cws_cmd_t;

  typedef struct packed {
    logic burst_start;
    logic burst_last;
    logic out_free;
  } cws_sts_t;

endpackage

// ===== hw/rtl/cws_in_if.sv =====
// ----------------------------------------------------------------------------
// cws_in_if: input channel of the congestion window sender
// Valid and ready handshake carrying one function code and an ack number.
// ----------------------------------------------------------------------------
interface cws_in_if import cws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [FUNC_W-1:0]   func;
  logic [SEQ_BITS-1:0] ack_number;

  modport source (output valid, output func, output ack_number, input ready);
  modport sink   (input valid, input func, input ack_number, output ready);
endinterface

// ===== hw/rtl/cws_out_if.sv =====
// ----------------------------------------------------------------------------
// cws_out_if: result channel of the congestion window sender
// Valid and ready handshake carrying one send, resend, ack, timeout or finish order.
// ----------------------------------------------------------------------------
interface cws_out_if import cws_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [SEQ_BITS-1:0] seq_number;
  logic [WIN_W-1:0]    window_size;
  logic [THR_W-1:0]    threshold_now;
  logic                last;

  modport source (output valid, output kind, output seq_number, output window_size,
                  output threshold_now, output last, input ready);
  modport sink   (input valid, input kind, input seq_number, input window_size,
                  input threshold_now, input last, output ready);
endinterface

// ===== hw/rtl/cws_ctrl.sv =====
// ----------------------------------------------------------------------------
// cws_ctrl: sequencing controller of the congestion window sender
// Takes one beat at a time, runs a single-result step or walks a send burst
// one result per cycle while the output register has room.
// ----------------------------------------------------------------------------
module cws_ctrl import cws_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  cws_sts_t sts,
  output cws_cmd_t cmd
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_EXEC  = 2'd1;
  localparam logic [1:0] ST_BURST = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_ready  = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = ST_EXEC;
        end
      end
      ST_EXEC: begin
        if (sts.burst_start) begin
          cmd.burst_init = 1'b1;
          state_nxt      = ST_BURST;
        end else if (sts.out_free) begin
          cmd.exec  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_BURST: begin
        if (sts.out_free) begin
          cmd.burst_step = 1'b1;
          if (sts.burst_last) begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> state_r == ST_EXEC)
    else $error("beat accepted without moving to execute");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.burst_step && sts.burst_last) |=> in_ready)
    else $error("controller not idle after the last burst result");

  assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.exec, cmd.burst_init, cmd.burst_step}))
    else $error("more than one datapath command in a cycle");

endmodule

// ===== hw/rtl/cws_dp.sv =====
// ----------------------------------------------------------------------------
// cws_dp: datapath of the congestion window sender
// Holds configuration, window and round state, the captured beat and the
// output register, and applies the commands issued by the controller.
// ----------------------------------------------------------------------------
module cws_dp import cws_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  input  logic [FUNC_W-1:0]     in_func,
  input  logic [SEQ_BITS-1:0]   in_ack_number,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [KIND_W-1:0]     out_kind,
  output logic [SEQ_BITS-1:0]   out_seq_number,
  output logic [WIN_W-1:0]      out_window_size,
  output logic [THR_W-1:0]      out_threshold_now,
  output logic                  out_last,
  input  cws_cmd_t              cmd,
  output cws_sts_t              sts
);

  logic [TOTAL_W-1:0]  total_r, total_nxt;
  logic [THR_W-1:0]    init_thr_r, init_thr_nxt;
  logic [TICK_W-1:0]   timeout_r, timeout_nxt;

  logic [SEQ_BITS-1:0] base_r, base_nxt;
  logic [SEQ_BITS:0]   hs_r, hs_nxt;
  logic [WIN_W-1:0]    window_r, window_nxt;
  logic [THR_W-1:0]    thr_r, thr_nxt;
  logic                below_r, below_nxt;
  logic [WIN_W-1:0]    sent_r, sent_nxt;
  logic [WIN_W-1:0]    acked_r, acked_nxt;
  logic                active_r, active_nxt;
  logic [TICK_W-1:0]   tick_r, tick_nxt;
  logic [WIN_W-1:0]    idx_r, idx_nxt;

  logic [FUNC_W-1:0]   func_r, func_nxt;
  logic [SEQ_BITS-1:0] ack_r, ack_nxt;

  logic                out_valid_r;
  logic [KIND_W-1:0]   kind_r;
  logic [SEQ_BITS-1:0] seq_r;
  logic [WIN_W-1:0]    win_out_r;
  logic [THR_W-1:0]    thr_out_r;
  logic                last_r;

  logic                wr;
  logic [KIND_W-1:0]   res_kind;
  logic [SEQ_BITS-1:0] res_seq;
  logic                res_last;

  logic [SEQ_BITS:0]   seq_sum;
  logic [SEQ_BITS:0]   next_sum;
  logic [SEQ_BITS-1:0] cur_seq;
  logic [WIN_W-1:0]    idx_inc;
  logic                is_new;
  logic [WIN_W-1:0]    win_grow;
  logic [WIN_W-1:0]    acked_inc;
  logic [TICK_W-1:0]   tick_inc;
  logic [WIN_W-1:0]    win_half;
  logic                below_now;

  assign seq_sum   = {1'b0, base_r} + (SEQ_BITS+1)'(idx_r);
  assign next_sum  = seq_sum + 1'b1;
  assign cur_seq   = seq_sum[SEQ_BITS-1:0];
  assign idx_inc   = idx_r + 1'b1;
  assign is_new    = hs_r[SEQ_BITS] || (cur_seq > hs_r[SEQ_BITS-1:0]);
  assign win_grow  = (window_r < MAX_WINDOW_W) ? window_r + 1'b1 : window_r;
  assign acked_inc = acked_r + 1'b1;
  assign tick_inc  = tick_r + 1'b1;
  assign win_half  = window_r >> 1;
  assign below_now = ((THR_W > WIN_W) ? THR_W'(window_r) : THR_W'(window_r)) < thr_r;

  assign sts.out_free    = !out_valid_r || out_ready;
  assign sts.burst_start = (func_r == FUNC_START) && !active_r
                           && ((SEQ_BITS+1)'(base_r) < (SEQ_BITS+1)'(total_r));
  assign sts.burst_last  = (idx_inc >= window_r) || (idx_inc >= MAX_WINDOW_W)
                           || (next_sum >= (SEQ_BITS+1)'(total_r));

  always_comb begin
    total_nxt    = total_r;
    init_thr_nxt = init_thr_r;
    timeout_nxt  = timeout_r;
    base_nxt     = base_r;
    hs_nxt       = hs_r;
    window_nxt   = window_r;
    thr_nxt      = thr_r;
    below_nxt    = below_r;
    sent_nxt     = sent_r;
    acked_nxt    = acked_r;
    active_nxt   = active_r;
    tick_nxt     = tick_r;
    idx_nxt      = idx_r;
    func_nxt     = func_r;
    ack_nxt      = ack_r;
    wr           = 1'b0;
    res_kind     = KIND_NONE;
    res_seq      = '0;
    res_last     = 1'b1;

    if (cmd.load) begin
      func_nxt = in_func;
      ack_nxt  = in_ack_number;
    end

    if (cmd.burst_init) begin
      idx_nxt = '0;
    end

    if (cmd.burst_step) begin
      wr       = 1'b1;
      idx_nxt  = idx_inc;
      res_seq  = cur_seq;
      res_last = sts.burst_last;
      if (is_new) begin
        res_kind = KIND_SEND;
        hs_nxt   = {1'b0, cur_seq};
      end else begin
        res_kind = KIND_RESEND;
      end
      if (sts.burst_last) begin
        sent_nxt   = idx_inc;
        acked_nxt  = '0;
        tick_nxt   = '0;
        active_nxt = 1'b1;
      end
    end

    if (cmd.exec) begin
      wr = 1'b1;
      case (func_r)
        FUNC_START: begin
          if (!active_r) begin
            res_kind = KIND_FIN;
          end
        end
        FUNC_ACK: begin
          if (active_r) begin
            below_nxt = below_now;
            if (ack_r == base_r) begin
              res_kind  = KIND_ACK;
              res_seq   = ack_r;
              base_nxt  = base_r + 1'b1;
              acked_nxt = acked_inc;
              if (below_now || (acked_inc == sent_r)) begin
                window_nxt = win_grow;
              end
              if (acked_inc == sent_r) begin
                active_nxt = 1'b0;
              end
            end
          end
        end
        FUNC_TICK: begin
          if (active_r) begin
            tick_nxt = tick_inc;
            if (tick_inc >= timeout_r) begin
              res_kind   = KIND_TIMEOUT;
              res_seq    = base_r;
              thr_nxt    = (win_half == '0) ? THR_W'(1) : THR_W'(win_half);
              window_nxt = WIN_W'(1);
              active_nxt = 1'b0;
              tick_nxt   = '0;
            end
          end
        end
        default: begin
          res_kind = KIND_NONE;
        end
      endcase
    end

    if (cfg_we) begin
      case (cfg_index)
        CFG_SEGMENT_TOTAL: begin
          total_nxt = cfg_data[TOTAL_W-1:0];
        end
        CFG_INITIAL_THRESHOLD: begin
          init_thr_nxt = cfg_data[THR_W-1:0];
          thr_nxt      = cfg_data[THR_W-1:0];
        end
        CFG_TIMEOUT_TICKS: begin
          timeout_nxt = cfg_data[TICK_W-1:0];
        end
        default: begin
          total_nxt = total_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      total_r     <= '0;
      init_thr_r  <= THR_RESET;
      timeout_r   <= TIMEOUT_RESET;
      base_r      <= '0;
      hs_r        <= '1;
      window_r    <= WIN_W'(1);
      thr_r       <= THR_RESET;
      below_r     <= 1'b1;
      sent_r      <= '0;
      acked_r     <= '0;
      active_r    <= 1'b0;
      tick_r      <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      total_r    <= total_nxt;
      init_thr_r <= init_thr_nxt;
      timeout_r  <= timeout_nxt;
      base_r     <= base_nxt;
      hs_r       <= hs_nxt;
      window_r   <= window_nxt;
      thr_r      <= thr_nxt;
      below_r    <= below_nxt;
      sent_r     <= sent_nxt;
      acked_r    <= acked_nxt;
      active_r   <= active_nxt;
      tick_r     <= tick_nxt;
      idx_r      <= idx_nxt;
      if (wr) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    func_r <= func_nxt;
    ack_r  <= ack_nxt;
    if (wr) begin
      kind_r    <= res_kind;
      seq_r     <= res_seq;
      win_out_r <= window_nxt;
      thr_out_r <= thr_nxt;
      last_r    <= res_last;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_kind          = kind_r;
  assign out_seq_number    = seq_r;
  assign out_window_size   = win_out_r;
  assign out_threshold_now = thr_out_r;
  assign out_last          = last_r;

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.burst_step && sts.burst_last) |=> active_r && (acked_r == '0))
    else $error("send burst finished without opening a round");

  assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (sent_r != '0) && (acked_r < sent_r))
    else $error("round counters inconsistent while a round is open");

  assert property (@(posedge clk) disable iff (!rst_n)
    (window_r != '0) && (window_r <= MAX_WINDOW_W))
    else $error("congestion window out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.burst_step && is_new) |=> hs_r == {1'b0, $past(cur_seq)})
    else $error("highest sent number not updated by a new send");

endmodule

// ===== hw/rtl/congestion_window_sender_top.sv =====
// ----------------------------------------------------------------------------
// congestion_window_sender_top: go-back-N sender with slow start
// Top level joining the sequencing controller and the window datapath.
// ----------------------------------------------------------------------------
// An ack, a tick or a start that gives a single order has its beat accepted,
// then its result computed into the output register. A start that opens a
// round has its beat accepted and the burst set up, then the controller walks
// the window one segment per cycle through the single output register while
// it has room, one send or resend order per segment. A result waiting at the
// output does not block the next beat from being accepted, but a stalled
// output holds the next result computation. Configuration writes land at
// once and must be made while the block is idle.
module congestion_window_sender_top import cws_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  cws_in_if.sink                in_if,
  cws_out_if.source             out_if
);

  cws_cmd_t cmd;
  cws_sts_t sts;

  cws_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_if.valid),
    .in_ready (in_if.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  cws_dp u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_data          (cfg_data),
    .in_func           (in_if.func),
    .in_ack_number     (in_if.ack_number),
    .out_valid         (out_if.valid),
    .out_ready         (out_if.ready),
    .out_kind          (out_if.kind),
    .out_seq_number    (out_if.seq_number),
    .out_window_size   (out_if.window_size),
    .out_threshold_now (out_if.threshold_now),
    .out_last          (out_if.last),
    .cmd               (cmd),
    .sts               (sts)
  );

endmodule
